// ===== design/dss_pkg.sv =====
// Shared types, codes and reset constants for the drum step sequencer.
package dss_pkg;

  localparam int STEPS_DEFAULT  = 8;
  localparam int VOICES_DEFAULT = 4;

  localparam int NOTE_W     = 7;
  localparam int TABLE_W    = 28;
  localparam int DEBOUNCE_W = 24;
  localparam int TIME_W     = 32;
  localparam int MASK_W     = 4;
  localparam int LED_W      = 8;

  localparam logic [TABLE_W-1:0]    NOTE_TABLE_RESET     = 28'd78255652;
  localparam logic [TABLE_W-1:0]    VELOCITY_TABLE_RESET = 28'd264201085;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET       = 24'd200000;

  localparam logic [7:0] ROW_RESET [4] = '{8'hAA, 8'hFF, 8'h55, 8'h01};

  typedef enum logic [1:0] {
    MODE_STEP_START = 2'd0,
    MODE_STEP_END   = 2'd1,
    MODE_VOICE_BTN  = 2'd2,
    MODE_STEP_BTN   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_NOTE_TABLE     = 2'd0,
    CFG_VELOCITY_TABLE = 2'd1,
    CFG_DEBOUNCE       = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_OUT
  } state_t;

endpackage

// ===== design/dss_press_check.sv =====
// Wrap-safe debounce compare: elapsed ticks since the last accepted press.
module dss_press_check (
  input  logic [dss_pkg::TIME_W-1:0]     press_time,
  input  logic [dss_pkg::TIME_W-1:0]     last_press,
  input  logic [dss_pkg::DEBOUNCE_W-1:0] debounce_ticks,
  output logic                           press_ok
);
  import dss_pkg::*;

  logic [TIME_W-1:0] elapsed;

  assign elapsed  = press_time - last_press;
  assign press_ok = elapsed >= TIME_W'(debounce_ticks);

endmodule

// ===== design/drum_step_sequencer_unit.sv =====
// Top level of the drum step sequencer: pattern state, sequencer and result register.
//
// Input channel (in_valid/in_stall) takes one event: mode selects step start,
// step end, voice button or step button; index and press_time serve the
// buttons. The block takes one event at a time and holds in_stall high until
// the last result of that event has been transferred.
// Output channel (out_valid/out_stall) gives one result per note-on of a step
// start, or one plain status result for every other event or a silent step.
// Each result shows the LED pattern and write mask after the event; last marks
// the final result of the event.
// After the input transfer the sequencer passes the EXEC and SCAN states
// before out_valid rises; SCAN also steps past each voice skipped before the
// first note of a step start. A step start walks the voices one per cycle
// with a single voice counter, pausing at each note until its result has been
// transferred. The debounce subtract/compare is one shared unit used once per
// button event.
// A stalled result holds in the output register and the sequencer waits.
// Configuration writes (cfg_valid/cfg_ready, ready always high) update the
// note, velocity and debounce registers; unknown indexes are dropped.
// Reset (rst, synchronous) restores the default pattern rows, tables and
// debounce window, clears LEDs, write mode, step and press time.
module drum_step_sequencer_unit #(
  parameter int NUM_STEPS  = dss_pkg::STEPS_DEFAULT,
  parameter int NUM_VOICES = dss_pkg::VOICES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [2:0]                    index,
  input  logic [dss_pkg::TIME_W-1:0]    press_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          note_valid,
  output logic [dss_pkg::NOTE_W-1:0]    note,
  output logic [dss_pkg::NOTE_W-1:0]    velocity,
  output logic [dss_pkg::LED_W-1:0]     led_pattern,
  output logic [dss_pkg::MASK_W-1:0]    write_mask,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [dss_pkg::TABLE_W-1:0]   cfg_data
);
  import dss_pkg::*;

  localparam int SW = $clog2(NUM_STEPS);
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  state_t state, state_next;

  logic [TABLE_W-1:0]    note_table;
  logic [TABLE_W-1:0]    velocity_table;
  logic [DEBOUNCE_W-1:0] debounce_ticks;

  logic [NUM_STEPS-1:0]  pattern [NUM_VOICES];
  logic [NUM_VOICES-1:0] write_bits;
  logic [NUM_STEPS-1:0]  led_bits;
  logic [SW-1:0]         current_step;
  logic [TIME_W-1:0]     last_press;

  mode_t             mode_r;
  logic [2:0]        index_r;
  logic [TIME_W-1:0] time_r;
  logic [VW-1:0]     voice;

  logic              press_ok;
  logic [NUM_VOICES-1:0] hits;
  logic              later_hit;
  logic              hit_now;
  logic [VW-1:0]     first_write;
  logic              in_take;
  logic              emit;
  logic              out_done;

  dss_press_check u_press_check (
    .press_time     (time_r),
    .last_press     (last_press),
    .debounce_ticks (debounce_ticks),
    .press_ok       (press_ok)
  );

  always_comb begin
    hits      = '0;
    later_hit = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      hits[v] = (mode_r == MODE_STEP_START) && pattern[v][current_step];
      if (hits[v] && (v > int'(voice))) later_hit = 1'b1;
    end
    hit_now = hits[voice];
  end

  always_comb begin
    first_write = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (write_bits[v]) first_write = VW'(v);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_SCAN;
      ST_SCAN: if (hit_now || (hits == '0)) state_next = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_next = last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    cfg_ready = 1'b1;
    in_take   = (state == ST_IDLE) && in_valid;
    emit      = (state == ST_SCAN) && (hit_now || (hits == '0));
    out_done  = (state == ST_OUT) && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_table     <= NOTE_TABLE_RESET;
      velocity_table <= VELOCITY_TABLE_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_NOTE_TABLE:     note_table     <= cfg_data;
        CFG_VELOCITY_TABLE: velocity_table <= cfg_data;
        CFG_DEBOUNCE:       debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r  <= mode_t'(mode);
      index_r <= index;
      time_r  <= press_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice <= '0;
    end else if (in_take) begin
      voice <= '0;
    end else if ((state == ST_SCAN) && !emit) begin
      voice <= voice + VW'(1);
    end else if (out_done && !last) begin
      voice <= voice + VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NUM_VOICES; v++) pattern[v] <= NUM_STEPS'(ROW_RESET[v]);
      write_bits   <= '0;
      led_bits     <= '0;
      current_step <= '0;
      last_press   <= '0;
    end else if (state == ST_EXEC) begin
      case (mode_r)
        MODE_STEP_START: begin
          led_bits <= led_bits ^ (NUM_STEPS'(1) << current_step);
        end
        MODE_STEP_END: begin
          led_bits <= led_bits ^ (NUM_STEPS'(1) << current_step);
          if (current_step == SW'(NUM_STEPS - 1)) current_step <= '0;
          else current_step <= current_step + SW'(1);
        end
        MODE_VOICE_BTN: begin
          if ((32'(index_r) < NUM_VOICES) && press_ok) begin
            last_press <= time_r;
            if (!write_bits[index_r[VW-1:0]]) begin
              led_bits <= led_bits ^ pattern[index_r[VW-1:0]];
              write_bits[index_r[VW-1:0]] <= 1'b1;
            end else begin
              led_bits <= NUM_STEPS'(1) << current_step;
              write_bits[index_r[VW-1:0]] <= 1'b0;
            end
          end
        end
        MODE_STEP_BTN: begin
          if ((32'(index_r) < NUM_STEPS) && (write_bits != '0) && press_ok) begin
            last_press <= time_r;
            pattern[first_write] <= pattern[first_write] ^ (NUM_STEPS'(1) << index_r);
            led_bits <= led_bits ^ (NUM_STEPS'(1) << index_r);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      note_valid  <= hit_now;
      note        <= hit_now ? note_table[NOTE_W*voice +: NOTE_W] : '0;
      velocity    <= hit_now ? velocity_table[NOTE_W*voice +: NOTE_W] : '0;
      led_pattern <= LED_W'(led_bits);
      write_mask  <= MASK_W'(write_bits);
      last        <= !later_hit;
    end
  end

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("output pending while input is open");

  a_take_to_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_EXEC))
    else $error("accepted event did not start execution");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !note_valid) |-> ((note == '0) && (velocity == '0) && last))
    else $error("status result carries note data or is not last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(last) && $stable(led_pattern)))
    else $error("stalled result changed");

endmodule
